[src/srs_pkg.sv]
`timescale 1ns / 1ps
package srs_pkg;

  localparam int TAPS = 24;
  localparam int LOG2_PHASES = 6;
  localparam int INTERP_WEIGHT_BITS = 14;
  localparam int PHASES = 1 << LOG2_PHASES;
  localparam int COEF_DEPTH = (PHASES + 2) * TAPS;
  localparam int COEF_AW = $clog2(COEF_DEPTH);
  localparam int ADDR_W = 11;
  localparam int TAP_W = $clog2(TAPS);
  localparam int DIST_W = $clog2(TAPS + 1);
  localparam int IX_W = TAP_W + 1;
  localparam int MAX_OUT = 16;
  localparam int CNT_W = $clog2(MAX_OUT + 1);
  localparam int DITHER_SHIFT = 17;
  localparam int OUT_SHIFT = 15;
  localparam int FRAMES_W = 40;
  localparam int POS_W = 64;
  localparam int CMP_W = FRAMES_W + 2;
  localparam int STEP_W = 37;
  localparam int CFG_W = 41;
  localparam int IDX_W = 3;
  localparam int PW = 16 + INTERP_WEIGHT_BITS + 2;
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW = 2;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_STEP = 3'd0,
    REG_START_POSITION = 3'd1,
    REG_DITHER_SEED = 3'd2,
    REG_LCG_MULT = 3'd3,
    REG_LCG_ADD = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_COEF,
    CMD_FRAME,
    CMD_DROP
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TAPS,
    ST_DRAIN,
    ST_FIN_L,
    ST_FIN_R
  } st_t;

  typedef struct packed {
    cmd_t cmd;
    logic [COEF_AW-1:0] addr;
    logic signed [15:0] coef;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } item_t;

  typedef struct packed {
    logic avail;
    item_t item;
  } fe_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic last;
  } result_t;

  function automatic logic [15:0] sat16(input logic [31:0] y);
    logic [31-OUT_SHIFT:0] q;
    logic [15:0] r;
    q = y[31:OUT_SHIFT];
    if (!q[31-OUT_SHIFT] && q[15]) begin
      r = 16'h7fff;
    end else if (q[31-OUT_SHIFT] && !q[15]) begin
      r = 16'h8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

endpackage

[src/srs_front.sv]
`timescale 1ns / 1ps
module srs_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic op,
  input  logic [srs_pkg::ADDR_W-1:0] coef_addr,
  input  logic signed [15:0] coef_value,
  input  logic signed [15:0] left_in,
  input  logic signed [15:0] right_in,
  input  logic take,
  output srs_pkg::fe_t fe
);

  srs_pkg::item_t mem [srs_pkg::FQ_DEPTH];
  logic [srs_pkg::FQ_AW-1:0] wr_ptr;
  logic [srs_pkg::FQ_AW-1:0] rd_ptr;
  logic [srs_pkg::FQ_AW:0] count;
  srs_pkg::item_t item;
  logic do_push;
  logic do_pop;

  // classify on the way in
  always_comb begin
    item.addr = coef_addr[srs_pkg::COEF_AW-1:0];
    item.coef = coef_value;
    item.left = left_in;
    item.right = right_in;
    if (op) begin
      item.cmd = srs_pkg::CMD_FRAME;
    end else if (coef_addr < srs_pkg::ADDR_W'(srs_pkg::COEF_DEPTH)) begin
      item.cmd = srs_pkg::CMD_COEF;
    end else begin
      item.cmd = srs_pkg::CMD_DROP;
    end
  end

  assign full = (count == (srs_pkg::FQ_AW + 1)'(srs_pkg::FQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop = take && (count != '0);
  assign fe.avail = (count != '0);
  assign fe.item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/srs_outq.sv]
`timescale 1ns / 1ps
module srs_outq (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  srs_pkg::result_t wdata,
  output logic oq_full,
  output logic empty,
  input  logic pop,
  output srs_pkg::result_t rdata
);

  srs_pkg::result_t mem [srs_pkg::OQ_DEPTH];
  logic [srs_pkg::OQ_AW-1:0] wr_ptr;
  logic [srs_pkg::OQ_AW-1:0] rd_ptr;
  logic [srs_pkg::OQ_AW:0] count;
  logic do_push;
  logic do_pop;

  assign oq_full = (count == (srs_pkg::OQ_AW + 1)'(srs_pkg::OQ_DEPTH));
  assign empty = (count == '0);
  assign do_push = wr && !oq_full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/srs_engine.sv]
`timescale 1ns / 1ps
module srs_engine (
  input  logic clk,
  input  logic rst,
  input  srs_pkg::fe_t fe,
  output logic take,
  input  logic oq_full,
  output logic oq_wr,
  output srs_pkg::result_t oq_data,
  input  logic cfg_write,
  input  logic [srs_pkg::IDX_W-1:0] cfg_index,
  input  logic [srs_pkg::CFG_W-1:0] cfg_data
);

  localparam int IW = srs_pkg::INTERP_WEIGHT_BITS;
  localparam int CW = srs_pkg::CMP_W;

  srs_pkg::st_t st;
  srs_pkg::st_t st_next;

  logic signed [15:0] coef_mem [srs_pkg::COEF_DEPTH];
  logic [31:0] frames [srs_pkg::TAPS];

  logic [srs_pkg::POS_W-1:0] position;
  logic [31:0] dstate;
  logic [srs_pkg::STEP_W-1:0] step;
  logic [31:0] lcg_mult;
  logic [31:0] lcg_add;
  logic [srs_pkg::FRAMES_W-1:0] nseen;
  logic [srs_pkg::TAP_W-1:0] wp;
  logic [srs_pkg::CNT_W-1:0] cnt;
  logic has_pend;
  logic [srs_pkg::TAP_W-1:0] t;
  logic va, vb, vc, vd;

  logic signed [CW-1:0] off_l;
  logic signed [CW-1:0] d0;
  logic [srs_pkg::COEF_AW-1:0] base0;
  logic [IW:0] w0;
  logic [IW-1:0] w1;

  logic signed [15:0] c0_q, c1_q;
  logic [31:0] smp_a, smp_b, smp_c;
  logic signed [srs_pkg::PW-1:0] p0, p1;
  logic signed [15:0] cq;
  logic signed [31:0] pl, pr;
  logic [31:0] accl, accr;
  logic [15:0] res_l, res_r;

  logic signed [31:0] off;
  logic signed [CW-1:0] off_x;
  logic cond;
  logic due;
  logic emit_ok;
  logic start_out;
  logic frame_in;
  logic coef_in;
  logic [31:0] dstate_adv;

  logic [srs_pkg::COEF_AW-1:0] ra0, ra1;
  logic signed [CW-1:0] k;
  logic signed [CW-1:0] d;
  logic in_win;
  logic [srs_pkg::DIST_W-1:0] dback;
  logic [srs_pkg::IX_W-1:0] ix_sum;
  logic [srs_pkg::TAP_W-1:0] idx;
  logic signed [srs_pkg::PW-1:0] psum;

  assign off = position[srs_pkg::POS_W-1:32];
  assign off_x = {{(CW - 32){off[31]}}, off};
  assign cond = (off_x + CW'(srs_pkg::TAPS)) <= $signed({2'b00, nseen});
  assign due = cond && (cnt < srs_pkg::CNT_W'(srs_pkg::MAX_OUT));
  assign emit_ok = !has_pend || !oq_full;
  assign frame_in = (st == srs_pkg::ST_IDLE) && fe.avail && (fe.item.cmd == srs_pkg::CMD_FRAME);
  assign coef_in = (st == srs_pkg::ST_IDLE) && fe.avail && (fe.item.cmd == srs_pkg::CMD_COEF);
  assign start_out = (st == srs_pkg::ST_CHECK) && emit_ok && due;
  assign dstate_adv = 32'(dstate * lcg_mult) + lcg_add;

  always_comb begin
    st_next = st;
    case (st)
      srs_pkg::ST_IDLE: begin
        if (frame_in) st_next = srs_pkg::ST_CHECK;
      end
      srs_pkg::ST_CHECK: begin
        if (emit_ok) st_next = due ? srs_pkg::ST_TAPS : srs_pkg::ST_IDLE;
      end
      srs_pkg::ST_TAPS: begin
        if (t == srs_pkg::TAP_W'(srs_pkg::TAPS - 1)) st_next = srs_pkg::ST_DRAIN;
      end
      srs_pkg::ST_DRAIN: begin
        if (!(va || vb || vc || vd)) st_next = srs_pkg::ST_FIN_L;
      end
      srs_pkg::ST_FIN_L: st_next = srs_pkg::ST_FIN_R;
      srs_pkg::ST_FIN_R: st_next = srs_pkg::ST_CHECK;
      default: st_next = srs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    take = (st == srs_pkg::ST_IDLE) && fe.avail;
    oq_wr = (st == srs_pkg::ST_CHECK) && has_pend && !oq_full;
    oq_data.left = res_l;
    oq_data.right = res_r;
    // the held result is last unless another output is due now
    oq_data.last = !due;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= srs_pkg::ST_IDLE;
      position <= '0;
      dstate <= '0;
      step <= srs_pkg::STEP_W'(64'h1_0000_0000);
      lcg_mult <= 32'd1664525;
      lcg_add <= 32'd1013904223;
      nseen <= '0;
      wp <= '0;
      cnt <= '0;
      has_pend <= 1'b0;
      t <= '0;
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      st <= st_next;
      va <= (st == srs_pkg::ST_TAPS);
      vb <= va;
      vc <= vb;
      vd <= vc;
      if (frame_in) begin
        nseen <= nseen + 1'b1;
        wp <= (wp == srs_pkg::TAP_W'(srs_pkg::TAPS - 1)) ? '0 : wp + 1'b1;
        cnt <= '0;
        has_pend <= 1'b0;
      end
      if ((st == srs_pkg::ST_CHECK) && emit_ok) begin
        has_pend <= 1'b0;
        t <= '0;
      end
      if (st == srs_pkg::ST_TAPS) begin
        t <= t + 1'b1;
      end
      if (st == srs_pkg::ST_FIN_L) begin
        dstate <= dstate_adv;
      end
      if (st == srs_pkg::ST_FIN_R) begin
        dstate <= dstate_adv;
        position <= position + srs_pkg::POS_W'(step);
        cnt <= cnt + 1'b1;
        has_pend <= 1'b1;
      end
      if (cfg_write) begin
        case (cfg_index)
          srs_pkg::REG_STEP: step <= cfg_data[srs_pkg::STEP_W-1:0];
          srs_pkg::REG_START_POSITION:
            position <= {{(srs_pkg::POS_W - srs_pkg::CFG_W){cfg_data[srs_pkg::CFG_W-1]}},
                         cfg_data};
          srs_pkg::REG_DITHER_SEED: dstate <= cfg_data[31:0];
          srs_pkg::REG_LCG_MULT: lcg_mult <= cfg_data[31:0];
          srs_pkg::REG_LCG_ADD: lcg_add <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (coef_in) begin
      coef_mem[fe.item.addr] <= fe.item.coef;
    end
    if (frame_in) begin
      frames[wp] <= {fe.item.right, fe.item.left};
    end
  end

  // tap issue: coefficient pair addresses and frame ring lookup
  always_comb begin
    ra0 = base0 + srs_pkg::COEF_AW'(t);
    ra1 = ra0 + srs_pkg::COEF_AW'(srs_pkg::TAPS);
    k = off_l + CW'(t);
    d = d0 - CW'(t);
    in_win = !k[CW-1] && !d[CW-1] && (d != '0) && (d <= CW'(srs_pkg::TAPS));
    dback = d[srs_pkg::DIST_W-1:0];
    if (srs_pkg::IX_W'(wp) >= srs_pkg::IX_W'(dback)) begin
      ix_sum = srs_pkg::IX_W'(wp) - srs_pkg::IX_W'(dback);
    end else begin
      ix_sum = srs_pkg::IX_W'(wp) + srs_pkg::IX_W'(srs_pkg::TAPS) - srs_pkg::IX_W'(dback);
    end
    idx = ix_sum[srs_pkg::TAP_W-1:0];
    psum = p0 + p1;
  end

  always_ff @(posedge clk) begin
    if (start_out) begin
      off_l <= off_x;
      d0 <= $signed({2'b00, nseen}) - off_x;
      base0 <= srs_pkg::COEF_AW'(position[31 -: srs_pkg::LOG2_PHASES] * srs_pkg::TAPS);
      w1 <= position[31 - srs_pkg::LOG2_PHASES -: IW];
      w0 <= (IW + 1)'(1 << IW) - (IW + 1)'(position[31 - srs_pkg::LOG2_PHASES -: IW]);
      accl <= '0;
      accr <= '0;
    end else if (vd) begin
      accl <= accl + pl;
      accr <= accr + pr;
    end
    c0_q <= coef_mem[ra0];
    c1_q <= coef_mem[ra1];
    smp_a <= in_win ? frames[idx] : 32'd0;
    p0 <= c0_q * $signed({1'b0, w0});
    p1 <= c1_q * $signed({2'b00, w1});
    smp_b <= smp_a;
    cq <= psum[IW+15:IW];
    smp_c <= smp_b;
    pl <= $signed(smp_c[15:0]) * cq;
    pr <= $signed(smp_c[31:16]) * cq;
    if (st == srs_pkg::ST_FIN_L) begin
      res_l <= srs_pkg::sat16(accl + 32'(dstate >> srs_pkg::DITHER_SHIFT));
    end
    if (st == srs_pkg::ST_FIN_R) begin
      res_r <= srs_pkg::sat16(accr + 32'(dstate >> srs_pkg::DITHER_SHIFT));
    end
  end

endmodule

[src/stereo_polyphase_resampler.sv]
`timescale 1ns / 1ps
// Stereo polyphase resampler. Items enter a four-deep input queue; a coefficient
// write is handled in the idle state alone, a frame push with no output in idle and
// check. Each output runs the taps one per cycle through a shared
// multiply-accumulate pipeline fed by the two read ports of the coefficient memory,
// up to 16 outputs per frame, left then right on the same result. Results wait in a
// four-deep queue; a full result queue stalls the engine while the input queue
// keeps taking items. The coefficient memory has no reset and no clearing pass:
// load every coefficient before pushing frames.
module stereo_polyphase_resampler (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic op,
  input  logic [10:0] coef_addr,
  input  logic signed [15:0] coef_value,
  input  logic signed [15:0] left_in,
  input  logic signed [15:0] right_in,
  output logic empty,
  input  logic pop,
  output logic signed [15:0] left_out,
  output logic signed [15:0] right_out,
  output logic last,
  input  logic cfg_write,
  input  logic [srs_pkg::IDX_W-1:0] cfg_index,
  input  logic [srs_pkg::CFG_W-1:0] cfg_data
);

  srs_pkg::fe_t fe;
  logic take;
  logic oq_full;
  logic oq_wr;
  srs_pkg::result_t oq_data;
  srs_pkg::result_t rdata;

  srs_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op),
    .coef_addr(coef_addr), .coef_value(coef_value),
    .left_in(left_in), .right_in(right_in), .take(take), .fe(fe)
  );

  srs_engine u_engine (
    .clk(clk), .rst(rst), .fe(fe), .take(take), .oq_full(oq_full),
    .oq_wr(oq_wr), .oq_data(oq_data), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  srs_outq u_outq (
    .clk(clk), .rst(rst), .wr(oq_wr), .wdata(oq_data), .oq_full(oq_full),
    .empty(empty), .pop(pop), .rdata(rdata)
  );

  assign left_out = rdata.left;
  assign right_out = rdata.right;
  assign last = rdata.last;

endmodule

[src/srs_checker.sv]
`timescale 1ns / 1ps
module srs_checker (
  input logic clk,
  input logic rst,
  input logic full,
  input logic empty,
  input logic pop,
  input logic signed [15:0] left_out,
  input logic signed [15:0] right_out,
  input logic last
);

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("input queue full after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("waiting result withdrawn");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(left_out) && $stable(right_out) && $stable(last))
    else $error("waiting result changed");

endmodule

bind stereo_polyphase_resampler srs_checker u_chk (.*);
